// ===== hw/rtl/tes_pkg.sv =====
// Package: payload types, codes and shared constants for the track error statistics block.
`default_nettype none
package tes_pkg;

    localparam int TRUTH_DEPTH_DEF = 256;

    typedef enum logic [1:0] {
        MODE_CLEAR = 2'd0,
        MODE_TRUTH = 2'd1,
        MODE_EST   = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_EMPTY   = 2'd1;
    localparam logic [1:0] STATUS_DROPPED = 2'd2;

    typedef struct packed {
        logic [1:0]         mode;
        logic [31:0]        sample_time;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] innov_x;
        logic signed [31:0] innov_y;
        logic               last;
    } t_in;

    typedef struct packed {
        logic [31:0]        rmse_pos;
        logic [31:0]        rmse_vel;
        logic [31:0]        peak_pos_error;
        logic signed [31:0] mean_innov_x;
        logic signed [31:0] mean_innov_y;
        logic [31:0]        estimate_total;
        logic [1:0]         status;
    } t_out;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FETCH,
        ST_FETCH_WAIT,
        ST_SQ,
        ST_SUM,
        ST_ROOT,
        ST_ACC,
        ST_DIV,
        ST_FIN_ROOT,
        ST_OUT
    } t_state;

endpackage
`default_nettype wire

// ===== hw/rtl/tes_ram.sv =====
// Generic single-port-write, registered-read RAM.
`default_nettype none
module tes_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/tes_front.sv =====
// Front end: input request queue of two entries that decouples acceptance from the engine.
`default_nettype none
module tes_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire tes_pkg::t_in  i_item,
    output logic               o_full,
    output logic               o_valid,
    output tes_pkg::t_in       o_item,
    input  wire logic          i_take
);
    import tes_pkg::*;

    t_in        r_q [2];
    logic       r_rd, n_rd, r_wr, n_wr;
    logic [1:0] r_cnt, n_cnt;
    logic       w_push, w_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_take && o_valid;

    always_comb begin
        n_rd  = w_pop ? !r_rd : r_rd;
        n_wr  = w_push ? !r_wr : r_wr;
        n_cnt = r_cnt + {1'b0, w_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_rd  <= n_rd;
            r_wr  <= n_wr;
            r_cnt <= n_cnt;
        end
        if (w_push) begin
            r_q[r_wr] <= i_item;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/tes_sqrt.sv =====
// Iterative integer square root of a 64-bit value, one result bit per cycle.
`default_nettype none
module tes_sqrt (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_val,
    output logic             o_done,
    output logic [31:0]      o_root
);
    logic [63:0] r_v;
    logic [63:0] r_r;
    logic [63:0] r_bit;
    logic        r_busy;
    logic [64:0] w_trial;

    assign w_trial = {1'b0, r_r} + {1'b0, r_bit};
    assign o_root  = r_r[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_v    <= i_val;
                r_r    <= 64'd0;
                r_bit  <= 64'd1 << 62;
            end else if (r_busy) begin
                if (r_bit == 64'd0) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end else begin
                    if ({1'b0, r_v} >= w_trial) begin
                        r_v <= r_v - w_trial[63:0];
                        r_r <= (r_r >> 1) + r_bit;
                    end else begin
                        r_r <= r_r >> 1;
                    end
                    r_bit <= r_bit >> 2;
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/tes_div.sv =====
// Iterative restoring divider: 64-bit unsigned dividend by 34-bit divisor, one bit per cycle.
`default_nettype none
module tes_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_num,
    input  wire logic [33:0] i_den,
    output logic             o_done,
    output logic [63:0]      o_quot
);
    logic [63:0] r_q;
    logic [34:0] r_rem;
    logic [33:0] r_den;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic [34:0] w_sh;

    assign w_sh   = {r_rem[33:0], r_q[63]};
    assign o_quot = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_q    <= i_num;
                r_rem  <= 35'd0;
                r_den  <= i_den;
                r_cnt  <= 7'd0;
            end else if (r_busy) begin
                if (w_sh >= {1'b0, r_den}) begin
                    r_rem <= w_sh - {1'b0, r_den};
                    r_q   <= {r_q[62:0], 1'b1};
                end else begin
                    r_rem <= w_sh;
                    r_q   <= {r_q[62:0], 1'b0};
                end
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/tes_back.sv =====
// Back end: truth table, nearest-time scan, error accumulation and final statistics.
`default_nettype none
module tes_back #(
    parameter int TRUTH_DEPTH = tes_pkg::TRUTH_DEPTH_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    input  wire tes_pkg::t_in i_item,
    output logic         o_take,
    output logic         o_res_valid,
    output tes_pkg::t_out o_res,
    input  wire logic    i_res_taken
);
    import tes_pkg::*;

    localparam int AW = (TRUTH_DEPTH > 1) ? $clog2(TRUTH_DEPTH) : 1;
    localparam int FW = $clog2(TRUTH_DEPTH + 1);

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic logic signed [63:0] sat_adds(input logic signed [63:0] a,
                                                    input logic signed [31:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        return s[63:0];
    endfunction

    t_state r_st, n_st;
    t_in    r_it;

    logic [FW-1:0] r_fill;
    logic          r_drop;
    logic [63:0]   r_ssp, r_ssv;
    logic signed [63:0] r_six, r_siy;
    logic [31:0]   r_peak, r_cnt;

    logic [FW-1:0] r_idx;
    logic          r_rvalid;
    logic [FW-1:0] r_ridx;
    logic [AW-1:0] r_best;
    logic [31:0]   r_bdist;
    logic [AW-1:0] w_raddr, w_waddr;
    logic          w_we;
    logic [31:0]   w_t, w_px, w_py, w_vx, w_vy;

    logic signed [32:0] r_ex, r_ey, r_evx, r_evy;
    logic [63:0]   r_sx, r_sy, r_svx, r_svy;
    logic [63:0]   r_d2, r_v2;
    logic [31:0]   r_perr;

    logic          r_phase;
    logic          r_dv_first;
    logic [31:0]   r_mx;
    logic          w_sq_start, w_sq_done, w_dv_start, w_dv_done;
    logic [63:0]   w_sq_val, w_quot, w_num;
    logic [33:0]   w_den;
    logic [31:0]   w_root;
    logic [2:0]    r_dstep;
    logic [63:0]   r_qpos, r_qvel;
    t_out          r_res;
    logic          r_res_valid;

    assign w_we    = (r_st == ST_IDLE) && i_valid && (i_item.mode == MODE_TRUTH)
                     && (r_fill < FW'(TRUTH_DEPTH));
    assign w_waddr = r_fill[AW-1:0];
    assign w_raddr = (r_st == ST_FETCH) ? r_best : r_idx[AW-1:0];

    tes_ram #(.WIDTH(32), .DEPTH(TRUTH_DEPTH)) u_t (.i_clk, .i_we(w_we),
        .i_waddr(w_waddr), .i_wdata(i_item.sample_time), .i_raddr(w_raddr), .o_rdata(w_t));
    tes_ram #(.WIDTH(32), .DEPTH(TRUTH_DEPTH)) u_px (.i_clk, .i_we(w_we),
        .i_waddr(w_waddr), .i_wdata(i_item.pos_x), .i_raddr(w_raddr), .o_rdata(w_px));
    tes_ram #(.WIDTH(32), .DEPTH(TRUTH_DEPTH)) u_py (.i_clk, .i_we(w_we),
        .i_waddr(w_waddr), .i_wdata(i_item.pos_y), .i_raddr(w_raddr), .o_rdata(w_py));
    tes_ram #(.WIDTH(32), .DEPTH(TRUTH_DEPTH)) u_vx (.i_clk, .i_we(w_we),
        .i_waddr(w_waddr), .i_wdata(i_item.vel_x), .i_raddr(w_raddr), .o_rdata(w_vx));
    tes_ram #(.WIDTH(32), .DEPTH(TRUTH_DEPTH)) u_vy (.i_clk, .i_we(w_we),
        .i_waddr(w_waddr), .i_wdata(i_item.vel_y), .i_raddr(w_raddr), .o_rdata(w_vy));

    // root unit: per-estimate error, then the two final roots
    assign w_sq_start = (r_st == ST_SUM) || (r_st == ST_DIV && w_dv_done && r_dstep == 3'd3)
                        || (r_st == ST_FIN_ROOT && w_sq_done && !r_phase);
    assign w_sq_val = (r_st == ST_SUM) ? sat_add(r_sx, r_sy)
                    : (r_st == ST_DIV) ? r_qpos : r_qvel;
    tes_sqrt u_sqrt (.i_clk, .i_rst_n, .i_start(w_sq_start), .i_val(w_sq_val),
        .o_done(w_sq_done), .o_root(w_root));

    // divider: pos, vel, |innov x|, |innov y|
    assign w_dv_start = ((r_st == ST_DIV) && r_dv_first) || ((r_st == ST_DIV) && w_dv_done
                        && r_dstep != 3'd3);
    always_comb begin
        w_num = r_ssp;
        w_den = {2'b0, r_cnt};
        unique case ((r_st == ST_DIV && r_dv_first) ? 3'd0 : r_dstep + 3'd1)
            3'd0: begin w_num = r_ssp; w_den = {2'b0, r_cnt}; end
            3'd1: begin w_num = r_ssv; w_den = {1'b0, r_cnt, 1'b0}; end
            3'd2: begin w_num = r_six[63] ? 64'(-r_six) : r_six; end
            3'd3: begin w_num = r_siy[63] ? 64'(-r_siy) : r_siy; end
            default: begin w_num = r_ssp; end
        endcase
    end
    tes_div u_div (.i_clk, .i_rst_n, .i_start(w_dv_start), .i_num(w_num), .i_den(w_den),
        .o_done(w_dv_done), .o_quot(w_quot));

    assign o_take      = (r_st == ST_IDLE) && i_valid;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE:       if (i_valid && i_item.mode == MODE_EST) begin
                               n_st = (r_fill == '0) ? ST_SQ : ST_SCAN;
                           end
            ST_SCAN:       if (r_rvalid && r_ridx == r_fill - FW'(1)) n_st = ST_FETCH;
            ST_FETCH:      n_st = ST_FETCH_WAIT;
            ST_FETCH_WAIT: n_st = ST_SQ;
            ST_SQ:         n_st = ST_SUM;
            ST_SUM:        n_st = ST_ROOT;
            ST_ROOT:       if (w_sq_done) n_st = ST_ACC;
            ST_ACC:        n_st = r_it.last ? ST_DIV : ST_IDLE;
            ST_DIV:        if (w_dv_done && r_dstep == 3'd3) n_st = ST_FIN_ROOT;
            ST_FIN_ROOT:   if (w_sq_done && r_phase) n_st = ST_OUT;
            ST_OUT:        if (!r_res_valid) n_st = ST_IDLE;
            default:       n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= ST_IDLE;
            r_fill      <= '0;
            r_drop      <= 1'b0;
            r_ssp       <= '0;
            r_ssv       <= '0;
            r_six       <= '0;
            r_siy       <= '0;
            r_peak      <= '0;
            r_cnt       <= '0;
            r_rvalid    <= 1'b0;
            r_dv_first  <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_res_valid && i_res_taken) r_res_valid <= 1'b0;
            unique case (r_st)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_it     <= i_item;
                        r_idx    <= '0;
                        r_rvalid <= 1'b0;
                        r_best   <= '0;
                        r_ex  <= 33'(i_item.pos_x);
                        r_ey  <= 33'(i_item.pos_y);
                        r_evx <= 33'(i_item.vel_x);
                        r_evy <= 33'(i_item.vel_y);
                        unique case (t_mode'(i_item.mode))
                            MODE_CLEAR: begin
                                r_fill <= '0; r_drop <= 1'b0;
                                r_ssp <= '0; r_ssv <= '0; r_six <= '0; r_siy <= '0;
                                r_peak <= '0; r_cnt <= '0;
                            end
                            MODE_TRUTH: begin
                                if (r_fill < FW'(TRUTH_DEPTH)) r_fill <= r_fill + FW'(1);
                                else r_drop <= 1'b1;
                            end
                            MODE_EST, MODE_NONE: ;
                            default: ;
                        endcase
                    end
                end
                ST_SCAN: begin
                    if (r_idx != r_fill) r_idx <= r_idx + FW'(1);
                    r_rvalid <= (r_idx != r_fill);
                    r_ridx   <= r_idx;
                    if (r_rvalid) begin
                        logic [31:0] d;
                        d = (w_t > r_it.sample_time) ? w_t - r_it.sample_time
                                                     : r_it.sample_time - w_t;
                        if (r_ridx == '0 || d < r_bdist) begin
                            r_best  <= r_ridx[AW-1:0];
                            r_bdist <= d;
                        end
                    end
                end
                ST_FETCH_WAIT: begin
                    r_ex  <= 33'(r_it.pos_x) - 33'($signed(w_px));
                    r_ey  <= 33'(r_it.pos_y) - 33'($signed(w_py));
                    r_evx <= 33'(r_it.vel_x) - 33'($signed(w_vx));
                    r_evy <= 33'(r_it.vel_y) - 33'($signed(w_vy));
                end
                ST_SQ: begin
                    logic [31:0] a, b, c, e;
                    a = r_ex[32]  ? 32'(-r_ex)  : r_ex[31:0];
                    b = r_ey[32]  ? 32'(-r_ey)  : r_ey[31:0];
                    c = r_evx[32] ? 32'(-r_evx) : r_evx[31:0];
                    e = r_evy[32] ? 32'(-r_evy) : r_evy[31:0];
                    r_sx  <= 64'(a) * 64'(a);
                    r_sy  <= 64'(b) * 64'(b);
                    r_svx <= 64'(c) * 64'(c);
                    r_svy <= 64'(e) * 64'(e);
                end
                ST_SUM: begin
                    r_d2 <= sat_add(r_sx, r_sy);
                    r_v2 <= sat_add(r_svx, r_svy);
                end
                ST_ROOT: if (w_sq_done) r_perr <= w_root;
                ST_ACC: begin
                    r_ssp <= sat_add(r_ssp, r_d2);
                    r_ssv <= sat_add(r_ssv, r_v2);
                    r_six <= sat_adds(r_six, r_it.innov_x);
                    r_siy <= sat_adds(r_siy, r_it.innov_y);
                    if (r_perr > r_peak) r_peak <= r_perr;
                    if (r_cnt != '1) r_cnt <= r_cnt + 32'd1;
                    r_dstep    <= 3'd0;
                    r_phase    <= 1'b0;
                    r_dv_first <= 1'b1;
                end
                ST_DIV: begin
                    r_dv_first <= 1'b0;
                    if (w_dv_done) begin
                        unique case (r_dstep)
                            3'd0: r_qpos <= w_quot;
                            3'd1: r_qvel <= w_quot;
                            3'd2: r_mx   <= r_six[63] ? 32'(-w_quot) : w_quot[31:0];
                            3'd3: r_res.mean_innov_y <= r_siy[63] ? 32'(-w_quot)
                                                                  : w_quot[31:0];
                            default: ;
                        endcase
                        r_dstep <= r_dstep + 3'd1;
                    end
                end
                ST_FIN_ROOT: if (w_sq_done) begin
                    if (!r_phase) r_res.rmse_pos <= w_root;
                    else begin
                        r_res.rmse_vel       <= w_root;
                        r_res.peak_pos_error <= r_peak;
                        r_res.mean_innov_x   <= r_mx;
                        r_res.estimate_total <= r_cnt;
                        r_res.status <= (r_fill == '0) ? STATUS_EMPTY
                                      : r_drop ? STATUS_DROPPED : STATUS_OK;
                        r_res_valid <= 1'b1;
                    end
                    r_phase <= 1'b1;
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/track_error_statistics_top.sv =====
// Top level of the track error statistics block.
// channel | dir | handshake          | payload
// input   | in  | push / full        | i_req  (t_in)
// result  | out | empty / pop        | o_res  (t_out)
// Truth loads and clears complete in the idle state; an estimate scans the truth table
// through its read port when the table is not empty; a last estimate adds four
// divides and two roots. A 2-entry input queue fronts the engine; a held result
// blocks further work until popped. Reset is synchronous, no clearing pass.
`default_nettype none
module track_error_statistics_top #(
    parameter int TRUTH_DEPTH = tes_pkg::TRUTH_DEPTH_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire tes_pkg::t_in i_req,
    output logic          empty,
    input  wire logic     pop,
    output tes_pkg::t_out o_res
);
    import tes_pkg::*;

    logic w_valid, w_take, w_rv;
    t_in  w_item;

    tes_front u_front (.i_clk, .i_rst_n, .i_push(push), .i_item(i_req), .o_full(full),
        .o_valid(w_valid), .o_item(w_item), .i_take(w_take));

    tes_back #(.TRUTH_DEPTH(TRUTH_DEPTH)) u_back (.i_clk, .i_rst_n, .i_valid(w_valid),
        .i_item(w_item), .o_take(w_take), .o_res_valid(w_rv), .o_res(o_res),
        .i_res_taken(pop));

    assign empty = !w_rv;
endmodule
`default_nettype wire

// ===== hw/rtl/tes_checker.sv =====
// Port-level checker for the track error statistics block, with its bind.
`default_nettype none
module tes_checker (
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    input wire logic     push,
    input wire logic     full,
    input wire logic     empty,
    input wire logic     pop,
    input wire tes_pkg::t_out o_res
);
    import tes_pkg::*;

    a_empty_rst: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result present after reset");
    a_not_full_rst: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("queue full after reset");
    a_full_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!full && !push) |=> !full)
        else $error("queue filled without a request");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_res)))
        else $error("result changed while waiting");
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_res.status != 2'd3 && o_res.estimate_total != 32'd0))
        else $error("bad status or count");
endmodule

bind track_error_statistics_top tes_checker u_tes_checker (.i_clk, .i_rst_n, .push, .full,
    .empty, .pop, .o_res);
`default_nettype wire
